// ===== hw/rtl/efd_pkg.sv =====
`default_nettype none

package efd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned FuncW   = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 8;

  localparam logic [ByteW-1:0] EndByteRst    = 8'd0;
  localparam logic [ByteW-1:0] EscapeByteRst = 8'd27;

  typedef enum logic [FuncW-1:0] {
    FUNC_BYTE  = 2'd0,
    FUNC_EOI   = 2'd1,
    FUNC_NEW   = 2'd2,
    FUNC_SPARE = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_DATA     = 3'd0,
    ST_CONSUMED = 3'd1,
    ST_FRAMEEND = 3'd2,
    ST_LEFTOVER = 3'd3,
    ST_EOD      = 3'd4,
    ST_ERROR    = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_END_BYTE    = 2'd0,
    CFG_ESCAPE_BYTE = 2'd1,
    CFG_FRAME_MODE  = 2'd2
  } cfg_idx_e;

  typedef enum logic [4:0] {
    PH_READING    = 5'b00001,
    PH_ESCAPED    = 5'b00010,
    PH_TERMINATED = 5'b00100,
    PH_EXHAUSTED  = 5'b01000,
    PH_ERROR      = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0]   out_byte;
    logic [StatusW-1:0] status;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/efd_stream_if.sv =====
`default_nettype none

interface efd_in_if;
  logic                          valid;
  logic                          ready;
  logic [efd_pkg::FuncW-1:0]     func;
  logic [efd_pkg::ByteW-1:0]     in_byte;

  modport source (output valid, output func, output in_byte, input ready);
  modport sink   (input valid, input func, input in_byte, output ready);
endinterface

interface efd_out_if;
  logic                          valid;
  logic                          ready;
  logic [efd_pkg::ByteW-1:0]     out_byte;
  logic [efd_pkg::StatusW-1:0]   status;

  modport source (output valid, output out_byte, output status, input ready);
  modport sink   (input valid, input out_byte, input status, output ready);
endinterface

interface efd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [efd_pkg::CfgIdxW-1:0]   index;
  logic [efd_pkg::CfgDatW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/escaped_frame_deframer_top.sv =====
`default_nettype none

// byte-stuffing deframer: one input beat (raw byte, end of input or new-frame
// command) gives exactly one result beat (decoded/leftover byte plus status).
// an unescaped end byte closes the frame, an escape byte is dropped and makes
// the following byte literal; detach mode passes bytes after the frame back as
// leftover, adopt mode flags them as a protocol error. an error holds until a
// new-frame command. throughput is one beat per clock while the skid is empty;
// the only loop is the phase register, updated in the same cycle a beat is
// taken. results sit in an output register backed by a skid register, so the
// input takes one more beat while a result waits; input ready is registered.
// the user must write configuration (end byte, escape byte, mode) through the
// config channel only while no beat is in flight; the block does not check it.
module escaped_frame_deframer_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  efd_in_if.sink     in_i,
  efd_out_if.source  out_o,
  efd_cfg_if.sink    cfg_i
);

  // configuration registers; writes to unknown indexes are dropped
  logic [efd_pkg::ByteW-1:0] end_byte_q;
  logic [efd_pkg::ByteW-1:0] escape_byte_q;
  logic                      frame_mode_q;

  // deframer state
  efd_pkg::phase_e phase_q, phase_d;

  // output register and skid register
  efd_pkg::result_t main_q, main_d, skid_q, skid_d, res;
  logic             main_v_q, main_v_d, skid_v_q, skid_v_d;

  logic in_fire, out_fire, cfg_fire;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  assign in_i.ready = ~skid_v_q;
  assign in_fire    = in_i.valid & ~skid_v_q;

  assign out_o.valid    = main_v_q;
  assign out_o.out_byte = main_q.out_byte;
  assign out_o.status   = main_q.status;
  assign out_fire       = main_v_q & out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_byte_q    <= efd_pkg::EndByteRst;
      escape_byte_q <= efd_pkg::EscapeByteRst;
      frame_mode_q  <= 1'b0;
    end else if (cfg_fire) begin
      unique case (efd_pkg::cfg_idx_e'(cfg_i.index))
        efd_pkg::CFG_END_BYTE:    end_byte_q    <= cfg_i.data;
        efd_pkg::CFG_ESCAPE_BYTE: escape_byte_q <= cfg_i.data;
        efd_pkg::CFG_FRAME_MODE:  frame_mode_q  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // one deframing step for the incoming beat
  always_comb begin
    phase_d      = phase_q;
    res.out_byte = '0;
    res.status   = efd_pkg::ST_CONSUMED;
    unique case (efd_pkg::func_e'(in_i.func))
      efd_pkg::FUNC_NEW: begin
        phase_d = efd_pkg::PH_READING;
      end
      efd_pkg::FUNC_BYTE: begin
        unique case (phase_q)
          efd_pkg::PH_READING: begin
            // end byte is tested first so it wins over an equal escape byte
            if (in_i.in_byte == end_byte_q) begin
              phase_d    = efd_pkg::PH_TERMINATED;
              res.status = efd_pkg::ST_FRAMEEND;
            end else if (in_i.in_byte == escape_byte_q) begin
              phase_d = efd_pkg::PH_ESCAPED;
            end else begin
              res.out_byte = in_i.in_byte;
              res.status   = efd_pkg::ST_DATA;
            end
          end
          efd_pkg::PH_ESCAPED: begin
            phase_d      = efd_pkg::PH_READING;
            res.out_byte = in_i.in_byte;
            res.status   = efd_pkg::ST_DATA;
          end
          efd_pkg::PH_TERMINATED: begin
            if (!frame_mode_q) begin
              res.out_byte = in_i.in_byte;
              res.status   = efd_pkg::ST_LEFTOVER;
            end else begin
              phase_d    = efd_pkg::PH_ERROR;
              res.status = efd_pkg::ST_ERROR;
            end
          end
          efd_pkg::PH_EXHAUSTED: begin
            res.status = efd_pkg::ST_EOD;
          end
          default: begin
            phase_d    = efd_pkg::PH_ERROR;
            res.status = efd_pkg::ST_ERROR;
          end
        endcase
      end
      efd_pkg::FUNC_EOI: begin
        unique case (phase_q)
          efd_pkg::PH_TERMINATED: begin
            // adopt mode: clean end of source; detach mode stays terminated
            if (frame_mode_q) begin
              phase_d = efd_pkg::PH_EXHAUSTED;
            end
            res.status = efd_pkg::ST_EOD;
          end
          efd_pkg::PH_EXHAUSTED: begin
            res.status = efd_pkg::ST_EOD;
          end
          default: begin
            // inside a frame, mid-escape, or already in error
            phase_d    = efd_pkg::PH_ERROR;
            res.status = efd_pkg::ST_ERROR;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= efd_pkg::PH_READING;
    end else if (in_fire) begin
      phase_q <= phase_d;
    end
  end

  // output register with skid behind it, order kept
  always_comb begin
    main_d   = main_q;
    skid_d   = skid_q;
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    if (out_fire) begin
      if (skid_v_q) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end else begin
        main_v_d = 1'b0;
      end
    end
    if (in_fire) begin
      if (!main_v_d) begin
        main_v_d = 1'b1;
        main_d   = res;
      end else begin
        skid_v_d = 1'b1;
        skid_d   = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/efd_checker.sv =====
`default_nettype none

module efd_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [efd_pkg::ByteW-1:0]     out_byte_i,
  input wire logic [efd_pkg::StatusW-1:0]   status_i
);

  logic in_fire;
  assign in_fire = in_valid_i & in_ready_i;

  // a result only appears after an input beat was taken
  a_result_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_fire))
    else $error("result beat without an input beat");

  // byte field is zero unless data or leftover
  a_byte_only_with_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i != efd_pkg::ST_DATA && status_i != efd_pkg::ST_LEFTOVER)
      |-> out_byte_i == '0)
    else $error("byte set on a non-data result");

  // status stays within its defined codes
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= efd_pkg::ST_ERROR)
    else $error("undefined status code");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i && $stable(status_i) && $stable(out_byte_i))
    else $error("stalled result beat changed");

endmodule

bind escaped_frame_deframer_top efd_checker u_efd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .status_i    (out_o.status)
);

`default_nettype wire

// ===== dv/efd_checker.sv =====
`default_nettype none

module efd_tb_checker import efd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  efd_in_if         in_mon,
  efd_out_if        out_mon,
  efd_cfg_if        cfg_mon,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ReportMax = 10;

  logic [ByteW-1:0] end_byte_q;
  logic [ByteW-1:0] escape_byte_q;
  logic             adopt_q;
  phase_e           phase_q;
  result_t          expected_q[$];
  int               failures = 0;

  // one step of the deframer, updates the predicted phase
  function automatic result_t deframe_beat(func_e f, logic [ByteW-1:0] b);
    result_t r;
    r.out_byte = '0;
    r.status   = ST_CONSUMED;
    case (f)
      FUNC_NEW: phase_q = PH_READING;
      FUNC_BYTE: begin
        case (phase_q)
          PH_READING: begin
            if (b == end_byte_q) begin
              phase_q  = PH_TERMINATED;
              r.status = ST_FRAMEEND;
            end else if (b == escape_byte_q) begin
              phase_q  = PH_ESCAPED;
            end else begin
              r.out_byte = b;
              r.status   = ST_DATA;
            end
          end
          PH_ESCAPED: begin
            phase_q    = PH_READING;
            r.out_byte = b;
            r.status   = ST_DATA;
          end
          PH_TERMINATED: begin
            if (!adopt_q) begin
              r.out_byte = b;
              r.status   = ST_LEFTOVER;
            end else begin
              phase_q  = PH_ERROR;
              r.status = ST_ERROR;
            end
          end
          PH_EXHAUSTED: r.status = ST_EOD;
          default: begin
            phase_q  = PH_ERROR;
            r.status = ST_ERROR;
          end
        endcase
      end
      FUNC_EOI: begin
        case (phase_q)
          PH_TERMINATED: begin
            if (adopt_q) phase_q = PH_EXHAUSTED;
            r.status = ST_EOD;
          end
          PH_EXHAUSTED: r.status = ST_EOD;
          default: begin
            phase_q  = PH_ERROR;
            r.status = ST_ERROR;
          end
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_failure(string msg);
    failures++;
    if (failures <= ReportMax) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      end_byte_q    = EndByteRst;
      escape_byte_q = EscapeByteRst;
      adopt_q       = 1'b0;
      phase_q       = PH_READING;
      expected_q.delete();
      pending_o    <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_e'(cfg_mon.index))
          CFG_END_BYTE:    end_byte_q    = cfg_mon.data;
          CFG_ESCAPE_BYTE: escape_byte_q = cfg_mon.data;
          CFG_FRAME_MODE:  adopt_q       = cfg_mon.data[0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          note_failure($sformatf("unexpected result: byte %02h status %0d",
                                 out_mon.out_byte, out_mon.status));
        end else begin
          want = expected_q.pop_front();
          if (out_mon.out_byte !== want.out_byte || out_mon.status !== want.status) begin
            note_failure($sformatf("mismatch: expected byte %02h status %0d, got byte %02h status %0d",
                                   want.out_byte, want.status,
                                   out_mon.out_byte, out_mon.status));
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_q.push_back(deframe_beat(func_e'(in_mon.func), in_mon.in_byte));
      end
      pending_o <= expected_q.size();
    end
    fail_count_o <= failures;
  end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import efd_pkg::*;

  localparam int unsigned ClkPeriod     = 20;
  localparam int unsigned ResetCycles   = 9;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned NumPhases     = 9;
  localparam int unsigned PhaseBeats    = 113;

  // index with no register behind it, writes must be dropped
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  // receiver stall patterns
  localparam int unsigned StallNone    = 0;
  localparam int unsigned StallRandom  = 1;
  localparam int unsigned StallPattern = 2;

  logic clk_i;
  logic rst_ni;

  efd_in_if  in_if ();
  efd_out_if out_if ();
  efd_cfg_if cfg_if ();

  int fail_count;
  int pending;

  // stimulus knobs; stall_mode and hold_off_req are shared with the receiver process
  int          beats_sent;
  int          burst_left;
  int          gap_max;
  int unsigned stall_mode;
  bit          hold_off_req;

  // current framing bytes, used to build well-formed frames
  logic [ByteW-1:0] cur_end;
  logic [ByteW-1:0] cur_esc;

  escaped_frame_deframer_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  efd_tb_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .cfg_mon      (cfg_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // receiver: own stall pattern, plus one long hold-off on request
  initial begin
    int unsigned tick;
    tick = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else begin
        case (stall_mode)
          StallRandom:  out_if.ready <= ($urandom_range(0, 3) != 0);
          StallPattern: out_if.ready <= ((tick % 7) >= 3);
          StallNone:    out_if.ready <= 1'b1;
          default:      out_if.ready <= 1'b1;
        endcase
      end
    end
  end

  // watchdog: too long without any beat on any channel
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb failed");
    $finish;
  end

  // offer one input beat; bursts of random length, random gaps between them
  task automatic send_beat(func_e f, logic [ByteW-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_if.valid   <= 1'b1;
    in_if.func    <= f;
    in_if.in_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    burst_left--;
    beats_sent++;
  endtask

  // leaves valid high, the caller drops it after the last write
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  task automatic load_config(logic [ByteW-1:0] e, logic [ByteW-1:0] esc,
                             logic [CfgDatW-1:0] mode_word);
    write_reg(CFG_END_BYTE, e);
    write_reg(CfgIdxSpare, 8'($urandom));
    write_reg(CFG_ESCAPE_BYTE, esc);
    write_reg(CFG_FRAME_MODE, mode_word);
    cfg_if.valid <= 1'b0;
    cur_end = e;
    cur_esc = esc;
  endtask

  // stop offering and let every outstanding result come out
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // payload byte, biased towards the framing bytes
  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return cur_end;
      1:       return cur_esc;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned      phase_target;
    int               payload_len;
    logic [ByteW-1:0] b;

    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.func    <= FUNC_BYTE;
    in_if.in_byte <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= CFG_END_BYTE;
    cfg_if.data   <= '0;
    beats_sent   = 0;
    burst_left   = 0;
    gap_max      = 3;
    stall_mode   = StallRandom;
    hold_off_req = 1'b0;
    cur_end      = EndByteRst;
    cur_esc      = EscapeByteRst;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset framing: end 00, escape 1b, detach mode
    send_beat(FUNC_BYTE, 8'hFF);            // plain data, all ones
    send_beat(FUNC_BYTE, 8'h55);
    send_beat(FUNC_BYTE, 8'hAA);
    send_beat(FUNC_BYTE, cur_esc);          // escape swallowed
    send_beat(FUNC_BYTE, cur_end);          // escaped terminator is data
    send_beat(FUNC_BYTE, cur_esc);
    send_beat(FUNC_BYTE, cur_esc);          // escaped escape is data
    send_beat(FUNC_BYTE, cur_end);          // frame end
    send_beat(FUNC_BYTE, 8'h80);            // leftover in detach mode
    send_beat(FUNC_EOI, 8'($urandom));      // end of data, stays terminated
    send_beat(FUNC_BYTE, 8'h7F);            // still leftover
    send_beat(FUNC_SPARE, 8'($urandom));    // unused code, ignored
    send_beat(FUNC_NEW, 8'($urandom));
    send_beat(FUNC_BYTE, 8'h01);
    send_beat(FUNC_EOI, 8'($urandom));      // end of input inside frame
    send_beat(FUNC_BYTE, 8'h00);            // error is sticky
    send_beat(FUNC_EOI, 8'($urandom));
    send_beat(FUNC_NEW, 8'($urandom));
    send_beat(FUNC_BYTE, cur_esc);
    send_beat(FUNC_EOI, 8'($urandom));      // end of input with escape pending
    send_beat(FUNC_NEW, 8'($urandom));
    send_beat(FUNC_BYTE, cur_end);          // empty frame

    // adopt mode, end byte equal to escape byte
    wait_drained();
    load_config(8'h7E, 8'h7E, 8'h01);
    send_beat(FUNC_BYTE, 8'h11);            // byte after frame is an error
    send_beat(FUNC_NEW, 8'($urandom));
    send_beat(FUNC_BYTE, 8'h7E);            // terminator wins over escape
    send_beat(FUNC_EOI, 8'($urandom));      // clean end, exhausted
    send_beat(FUNC_BYTE, 8'h42);            // ignored once exhausted
    send_beat(FUNC_EOI, 8'($urandom));
    send_beat(FUNC_NEW, 8'($urandom));

    // random phases, each under its own framing and flow pattern
    for (int p = 0; p < NumPhases; p++) begin
      // sender pauses until every result is back, then reconfigure
      wait_drained();
      b = 8'($urandom);
      case (p)
        0:       load_config(8'h00, 8'hFF, 8'h00);
        1:       load_config(8'hFF, 8'h00, 8'hFF);
        2:       load_config(b, b, 8'($urandom));
        default: load_config(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      gap_max    = (p % 3 == 0) ? 0 : $urandom_range(2, 10);
      stall_mode = (p + 1) % 3;
      // long receiver hold-off while the sender keeps pushing
      if (p == 3) hold_off_req = 1'b1;
      phase_target = beats_sent + PhaseBeats;

      while (beats_sent < phase_target) begin
        if ($urandom_range(0, 5) == 0) begin
          // noise: any code, any byte
          repeat ($urandom_range(1, 6)) send_beat(func_e'($urandom_range(0, 3)), 8'($urandom));
        end else begin
          send_beat(FUNC_NEW, 8'($urandom));
          payload_len = $urandom_range(0, 10);
          repeat (payload_len) begin
            b = pick_byte();
            // framing bytes are mostly escaped, sometimes left bare
            if ((b == cur_end || b == cur_esc) && $urandom_range(0, 9) != 0) begin
              send_beat(FUNC_BYTE, cur_esc);
            end
            send_beat(FUNC_BYTE, b);
          end
          case ($urandom_range(0, 9))
            8:       send_beat(FUNC_EOI, 8'($urandom));   // truncated frame
            9:       ;                                    // no terminator
            default: send_beat(FUNC_BYTE, cur_end);
          endcase
          // trailing bytes or end of input after the frame
          repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 2) == 0) send_beat(FUNC_EOI, 8'($urandom));
            else send_beat(FUNC_BYTE, pick_byte());
          end
        end
      end
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/efd_pkg.sv
hw/rtl/efd_stream_if.sv
hw/rtl/escaped_frame_deframer_top.sv
hw/rtl/efd_checker.sv
dv/efd_checker.sv
dv/tb.sv
